### hw/rtl/lap_pkg.sv
package lap_pkg;

    // coordinate field width and basis component width (signed Q1.16)
    localparam int CW = 21;
    localparam int BW = 18;

    // configuration register indexes
    localparam logic [2:0] REG_POSITION = 3'd0;
    localparam logic [2:0] REG_TARGET   = 3'd1;
    localparam logic [2:0] REG_UP       = 3'd2;
    localparam logic [2:0] REG_FOCAL    = 3'd3;
    localparam logic [2:0] REG_NEAR     = 3'd4;

    localparam logic [23:0]        FOCAL_RESET = 24'd65536;
    localparam logic signed [20:0] NEAR_RESET  = 21'sd16;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MAG,
        B_SQ,
        B_SQRT,
        B_DLD,
        B_DIV,
        B_NEXT,
        B_CROSS,
        B_FIN
    } t_bstate;

    typedef logic [2:0][BW-1:0] t_vec3;

    typedef struct packed {
        logic  ok;
        t_vec3 fwd;
        t_vec3 rgt;
        t_vec3 upc;
    } t_basis;

endpackage

### hw/rtl/lap_pt_if.sv
interface lap_pt_if import lap_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

### hw/rtl/lap_res_if.sv
interface lap_res_if ();
    logic               valid;
    logic               ready;
    logic               visible;
    logic signed [19:0] pix_x;
    logic signed [19:0] pix_y;

    modport source (output valid, output visible, output pix_x, output pix_y,
                    input ready);
    modport sink (input valid, input visible, input pix_x, input pix_y,
                  output ready);
endinterface

### hw/rtl/lap_cfg_if.sv
interface lap_cfg_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [62:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/lap_basis.sv
module lap_basis import lap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_position,
    input  logic [62:0] i_target,
    input  logic [62:0] i_up,
    output logic        o_busy,
    output t_basis      o_basis
);

    t_bstate r_state, n_state;
    logic    r_pass;
    logic    r_ok;

    logic signed [38:0]   r_vec [3];
    logic [30:0]          r_m [3];
    logic [2:0]           r_neg;
    logic [63:0]          r_acc;
    logic [63:0]          r_root;
    logic [47:0]          r_rem;
    logic [16:0]          r_q;
    logic [4:0]           r_cnt;
    logic [2:0]           r_idx;
    logic signed [BW-1:0] r_res [3];
    logic signed [BW-1:0] r_fwd [3];
    logic signed [BW-1:0] r_rgt [3];
    logic signed [BW-1:0] r_upc [3];

    logic signed [21:0]   w_d [3];
    logic [38:0]          w_mag [3];
    logic [38:0]          w_mx;
    logic [3:0]           w_s;
    logic [61:0]          w_sq;
    logic [63:0]          w_bit;
    logic [63:0]          w_trial;
    logic                 w_sq_ge;
    logic [47:0]          w_dld;
    logic [47:0]          w_dsh;
    logic                 w_div_ge;
    logic [16:0]          w_qn;
    logic signed [BW-1:0] w_qs;
    logic signed [CW-1:0] w_a [3];
    logic signed [CW-1:0] w_b [3];
    logic signed [CW-1:0] w_pa;
    logic signed [CW-1:0] w_pb;
    logic [1:0]           w_comp;
    logic                 w_sub;
    logic signed [38:0]   w_prod;
    logic signed [39:0]   w_rnd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = 22'($signed(i_target[CW*i +: CW])) - 22'($signed(i_position[CW*i +: CW]));
            w_mag[i] = r_vec[i][38] ? 39'(-r_vec[i]) : 39'(r_vec[i]);
            w_a[i] = r_pass ? CW'(r_fwd[i]) : $signed(i_up[CW*i +: CW]);
            w_b[i] = r_pass ? CW'(r_rgt[i]) : CW'(r_fwd[i]);
            w_rnd[i] = 40'(r_vec[i]) + 40'sd32768;
        end
        w_mx = w_mag[0];
        if (w_mag[1] > w_mx) w_mx = w_mag[1];
        if (w_mag[2] > w_mx) w_mx = w_mag[2];
        // smallest shift that brings the largest magnitude below 2^31
        w_s = 4'd0;
        for (int s = 8; s >= 0; s--) begin
            if ((w_mx >> s) < 39'h0080000000) w_s = 4'(s);
        end
    end

    // squares, integer square root and rounded divide
    always_comb begin
        w_sq     = r_m[r_idx[1:0]] * r_m[r_idx[1:0]];
        w_bit    = 64'd1 << {r_cnt, 1'b0};
        w_trial  = r_root + w_bit;
        w_sq_ge  = r_acc >= w_trial;
        w_dld    = 48'({r_m[r_idx[1:0]], 16'b0}) + 48'(r_root[31:1]);
        w_dsh    = 48'(r_root[31:0]) << r_cnt;
        w_div_ge = r_rem >= w_dsh;
        w_qn     = r_q | (w_div_ge ? (17'd1 << r_cnt) : 17'd0);
        w_qs     = $signed({1'b0, w_qn});
    end

    // cross product, one partial product a cycle
    always_comb begin
        case (r_idx)
            3'd0: begin w_pa = w_a[1]; w_pb = w_b[2]; w_comp = 2'd0; w_sub = 1'b0; end
            3'd1: begin w_pa = w_a[2]; w_pb = w_b[1]; w_comp = 2'd0; w_sub = 1'b1; end
            3'd2: begin w_pa = w_a[2]; w_pb = w_b[0]; w_comp = 2'd1; w_sub = 1'b0; end
            3'd3: begin w_pa = w_a[0]; w_pb = w_b[2]; w_comp = 2'd1; w_sub = 1'b1; end
            3'd4: begin w_pa = w_a[0]; w_pb = w_b[1]; w_comp = 2'd2; w_sub = 1'b0; end
            3'd5: begin w_pa = w_a[1]; w_pb = w_b[0]; w_comp = 2'd2; w_sub = 1'b1; end
            default: begin w_pa = w_a[0]; w_pb = w_b[0]; w_comp = 2'd0; w_sub = 1'b0; end
        endcase
        w_prod = w_pa * w_pb;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (i_start) n_state = B_MAG;
            B_MAG:   n_state = B_SQ;
            B_SQ:    if (r_idx == 3'd2) n_state = B_SQRT;
            B_SQRT:  if (r_cnt == 5'd0) n_state = B_DLD;
            B_DLD:   n_state = (r_root == 64'd0) ? B_IDLE : B_DIV;
            B_DIV: begin
                if (r_cnt == 5'd0) n_state = (r_idx == 3'd2) ? B_NEXT : B_DLD;
            end
            B_NEXT:  n_state = B_CROSS;
            B_CROSS: if (r_idx == 3'd5) n_state = r_pass ? B_FIN : B_MAG;
            B_FIN:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_busy     = (r_state != B_IDLE);
        o_basis.ok = r_ok;
        for (int i = 0; i < 3; i++) begin
            o_basis.fwd[i] = r_fwd[i];
            o_basis.rgt[i] = r_rgt[i];
            o_basis.upc[i] = r_upc[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ok    <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_pass <= 1'b0;
                        r_ok   <= 1'b0;
                        for (int i = 0; i < 3; i++) r_vec[i] <= 39'(w_d[i]);
                    end
                end
                B_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i]   <= 31'(w_mag[i] >> w_s);
                        r_neg[i] <= r_vec[i][38];
                    end
                    r_acc <= 64'd0;
                    r_idx <= 3'd0;
                end
                B_SQ: begin
                    r_acc <= r_acc + 64'(w_sq);
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd2) begin
                        r_cnt  <= 5'd31;
                        r_root <= 64'd0;
                        r_idx  <= 3'd0;
                    end
                end
                B_SQRT: begin
                    if (w_sq_ge) begin
                        r_acc  <= r_acc - w_trial;
                        r_root <= (r_root >> 1) + w_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_cnt <= r_cnt - 5'd1;
                end
                B_DLD: begin
                    r_rem <= w_dld;
                    r_cnt <= 5'd16;
                    r_q   <= 17'd0;
                end
                B_DIV: begin
                    if (w_div_ge) r_rem <= r_rem - w_dsh;
                    r_q   <= w_qn;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_res[r_idx[1:0]] <= r_neg[r_idx[1:0]] ? -w_qs : w_qs;
                        r_idx <= r_idx + 3'd1;
                    end
                end
                B_NEXT: begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_pass) r_rgt[i] <= r_res[i];
                        else r_fwd[i] <= r_res[i];
                        r_vec[i] <= 39'sd0;
                    end
                    r_idx <= 3'd0;
                end
                B_CROSS: begin
                    r_vec[w_comp] <= w_sub ? r_vec[w_comp] - w_prod : r_vec[w_comp] + w_prod;
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd5) r_pass <= 1'b1;
                end
                B_FIN: begin
                    for (int i = 0; i < 3; i++) r_upc[i] <= BW'(w_rnd[i] >>> 16);
                    r_ok <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

### hw/rtl/look_at_perspective_projection.sv
// Look-at perspective projection: one world point (signed Q16.4) in, one screen
// position (signed Q15.4, saturated) and a visible flag out. The camera basis is
// computed once per write of position, target or up by a sequential unit (one
// shared square-root and divide datapath); while it runs the point input and the
// configuration port hold ready low. Focal length and near plane writes take
// effect at once. With a valid basis and no stall on the result side the
// projection pipeline takes one item every clock; most of its stages are the two
// 41-stage restoring dividers that form x*f/depth and y*f/depth. A stall on the
// result side freezes the whole pipeline, nothing is dropped or repeated.
// Points at or inside the near plane, or with a degenerate basis, come out with
// visible low and zero coordinates.
module look_at_perspective_projection import lap_pkg::*; #(
    parameter int SCREEN_WIDTH  = 1280,
    parameter int SCREEN_HEIGHT = 720
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lap_pt_if.sink     i_pt,
    lap_res_if.source  o_res,
    lap_cfg_if.sink    i_cfg
);

    localparam int HB = $clog2(SCREEN_HEIGHT + 1);
    localparam int PW = 41 + HB + 1;
    localparam int ND = 41;
    localparam logic signed [47:0] XC = 48'(SCREEN_WIDTH * 8);
    localparam logic signed [47:0] YC = 48'(SCREEN_HEIGHT * 8);
    localparam logic [40:0] QLIM = 41'd1 << 40;

    // configuration registers
    logic [62:0]          r_position;
    logic [62:0]          r_target;
    logic [62:0]          r_up;
    logic [23:0]          r_focal;
    logic signed [20:0]   r_near;
    logic                 r_start;

    logic                 w_busy;
    t_basis               w_basis;
    logic                 w_cfg_wr;
    logic                 w_en;
    logic                 w_acc;

    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = !w_busy && !r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_target   <= '0;
            r_up       <= '0;
            r_focal    <= FOCAL_RESET;
            r_near     <= NEAR_RESET;
            r_start    <= 1'b0;
        end else begin
            // basis recompute starts the cycle after a camera register changes
            r_start <= 1'b0;
            if (w_cfg_wr) begin
                case (i_cfg.index)
                    REG_POSITION: begin r_position <= i_cfg.data; r_start <= 1'b1; end
                    REG_TARGET:   begin r_target <= i_cfg.data;   r_start <= 1'b1; end
                    REG_UP:       begin r_up <= i_cfg.data;       r_start <= 1'b1; end
                    REG_FOCAL:    r_focal <= i_cfg.data[23:0];
                    REG_NEAR:     r_near <= $signed(i_cfg.data[20:0]);
                    default: ;
                endcase
            end
        end
    end

    lap_basis u_basis (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_position (r_position),
        .i_target   (r_target),
        .i_up       (r_up),
        .o_busy     (w_busy),
        .o_basis    (w_basis)
    );

    // global pipeline advance, the output register is the last stage
    logic r_o_valid;
    assign w_en       = !r_o_valid || o_res.ready;
    assign i_pt.ready = w_en && !w_busy && !r_start;
    assign w_acc      = i_pt.valid && i_pt.ready;

    // stage 1: point relative to the camera
    logic signed [CW-1:0] w_pt [3];
    logic                 r_v1;
    logic signed [21:0]   r_rel [3];

    assign w_pt[0] = i_pt.point_x;
    assign w_pt[1] = i_pt.point_y;
    assign w_pt[2] = i_pt.point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_acc;
            for (int i = 0; i < 3; i++) begin
                r_rel[i] <= 22'(w_pt[i]) - 22'($signed(r_position[CW*i +: CW]));
            end
        end
    end

    // stage 2: nine products against right, up and forward
    logic signed [BW-1:0] w_bas [3][3];
    logic                 r_v2;
    logic signed [39:0]   r_prod [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_bas[0][i] = $signed(w_basis.rgt[i]);
            w_bas[1][i] = $signed(w_basis.upc[i]);
            w_bas[2][i] = $signed(w_basis.fwd[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) r_prod[j][i] <= r_rel[i] * w_bas[j][i];
            end
        end
    end

    // stage 3: camera-space x, y and depth (20 fraction bits)
    logic               r_v3;
    logic signed [41:0] r_cam [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
            for (int j = 0; j < 3; j++) begin
                r_cam[j] <= 42'(r_prod[j][0]) + 42'(r_prod[j][1]) + 42'(r_prod[j][2]);
            end
        end
    end

    // stage 4: near plane test and numerators |x|*f, |y|*f
    logic signed [41:0] w_nearq;
    logic               w_vis;
    logic [38:0]        w_mx;
    logic [38:0]        w_my;
    logic               r_v4;
    logic               r_vis4;
    logic [62:0]        r_nx4;
    logic [62:0]        r_ny4;
    logic [38:0]        r_dep4;
    logic               r_sx4;
    logic               r_sy4;

    always_comb begin
        w_nearq = 42'($signed({r_near, 16'b0}));
        w_vis   = w_basis.ok && (r_cam[2] > w_nearq) && (r_cam[2] > 42'sd0);
        w_mx    = r_cam[0][41] ? 39'(-r_cam[0]) : 39'(r_cam[0]);
        w_my    = r_cam[1][41] ? 39'(-r_cam[1]) : 39'(r_cam[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4   <= r_v3;
            r_vis4 <= w_vis;
            r_nx4  <= w_mx * r_focal;
            r_ny4  <= w_my * r_focal;
            r_dep4 <= w_vis ? r_cam[2][38:0] : 39'd1;
            r_sx4  <= r_cam[0][41];
            r_sy4  <= r_cam[1][41];
        end
    end

    // divider stages: stage 0 flags quotients of 2^41 or more, then one bit each
    logic        r_vd   [ND+1];
    logic        r_visd [ND+1];
    logic [62:0] r_rx   [ND+1];
    logic [62:0] r_ry   [ND+1];
    logic [40:0] r_qx   [ND+1];
    logic [40:0] r_qy   [ND+1];
    logic [38:0] r_dep  [ND+1];
    logic        r_clx  [ND+1];
    logic        r_cly  [ND+1];
    logic        r_sgx  [ND+1];
    logic        r_sgy  [ND+1];
    logic [79:0] w_dtop;

    assign w_dtop = 80'(r_dep4) << ND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (w_en) begin
            r_vd[0]   <= r_v4;
            r_visd[0] <= r_vis4;
            r_rx[0]   <= r_nx4;
            r_ry[0]   <= r_ny4;
            r_qx[0]   <= 41'd0;
            r_qy[0]   <= 41'd0;
            r_dep[0]  <= r_dep4;
            r_clx[0]  <= 80'(r_nx4) >= w_dtop;
            r_cly[0]  <= 80'(r_ny4) >= w_dtop;
            r_sgx[0]  <= r_sx4;
            r_sgy[0]  <= r_sy4;
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        localparam int SH = ND - 1 - k;
        logic [79:0] w_dsh;
        logic        w_gex;
        logic        w_gey;

        always_comb begin
            w_dsh = 80'(r_dep[k]) << SH;
            w_gex = 80'(r_rx[k]) >= w_dsh;
            w_gey = 80'(r_ry[k]) >= w_dsh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else if (w_en) begin
                r_vd[k+1]   <= r_vd[k];
                r_visd[k+1] <= r_visd[k];
                r_rx[k+1]   <= w_gex ? 63'(80'(r_rx[k]) - w_dsh) : r_rx[k];
                r_ry[k+1]   <= w_gey ? 63'(80'(r_ry[k]) - w_dsh) : r_ry[k];
                r_qx[k+1]   <= r_qx[k] | (w_gex ? (41'd1 << SH) : 41'd0);
                r_qy[k+1]   <= r_qy[k] | (w_gey ? (41'd1 << SH) : 41'd0);
                r_dep[k+1]  <= r_dep[k];
                r_clx[k+1]  <= r_clx[k];
                r_cly[k+1]  <= r_cly[k];
                r_sgx[k+1]  <= r_sgx[k];
                r_sgy[k+1]  <= r_sgy[k];
            end
        end
    end

    // term stage: limit to 2^40, scale by half screen height, unsigned Q37.4 with rounding
    logic [40:0]   w_qfx;
    logic [40:0]   w_qfy;
    logic [PW-1:0] w_px;
    logic [PW-1:0] w_py;
    logic          r_vt;
    logic          r_vist;
    logic [40:0]   r_tx;
    logic [40:0]   r_ty;
    logic          r_sgxt;
    logic          r_sgyt;

    always_comb begin
        w_qfx = (r_clx[ND] || (r_qx[ND] > QLIM)) ? QLIM : r_qx[ND];
        w_qfy = (r_cly[ND] || (r_qy[ND] > QLIM)) ? QLIM : r_qy[ND];
        w_px  = PW'(w_qfx) * PW'(SCREEN_HEIGHT) + PW'(4096);
        w_py  = PW'(w_qfy) * PW'(SCREEN_HEIGHT) + PW'(4096);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt <= 1'b0;
        end else if (w_en) begin
            r_vt   <= r_vd[ND];
            r_vist <= r_visd[ND];
            r_tx   <= 41'(w_px >> 13);
            r_ty   <= 41'(w_py >> 13);
            r_sgxt <= r_sgx[ND];
            r_sgyt <= r_sgy[ND];
        end
    end

    // output stage: center, apply sign, saturate
    logic signed [47:0] w_tx;
    logic signed [47:0] w_ty;
    logic signed [47:0] w_sx;
    logic signed [47:0] w_sy;
    logic signed [19:0] w_satx;
    logic signed [19:0] w_saty;
    logic               r_o_vis;
    logic signed [19:0] r_o_sx;
    logic signed [19:0] r_o_sy;

    always_comb begin
        w_tx = $signed({7'b0, r_tx});
        w_ty = $signed({7'b0, r_ty});
        w_sx = XC + (r_sgxt ? -w_tx : w_tx);
        w_sy = YC - (r_sgyt ? -w_ty : w_ty);
        if (w_sx > 48'sd524287) w_satx = 20'sd524287;
        else if (w_sx < -48'sd524288) w_satx = -20'sd524288;
        else w_satx = 20'(w_sx);
        if (w_sy > 48'sd524287) w_saty = 20'sd524287;
        else if (w_sy < -48'sd524288) w_saty = -20'sd524288;
        else w_saty = 20'(w_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_vt;
            r_o_vis   <= r_vist;
            r_o_sx    <= r_vist ? w_satx : 20'sd0;
            r_o_sy    <= r_vist ? w_saty : 20'sd0;
        end
    end

    assign o_res.valid   = r_o_valid;
    assign o_res.visible = r_o_vis;
    assign o_res.pix_x   = r_o_sx;
    assign o_res.pix_y   = r_o_sy;

endmodule
